/* hw/rtl/dmx_pkg.sv */
// Shared types, constants and the logarithmic curve table for the DMX512 slot receiver.
package dmx_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 10;
    localparam int CH_W      = 3;
    localparam int SUM_W     = 16;
    localparam int STORED_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // Frame geometry.
    localparam int NUM_CHANNELS = 6;
    localparam int MAX_SLOT     = 512;
    localparam int CMD_LEN      = 5;
    localparam int CMD_IDX_W    = 3;

    // Start codes and command bytes.
    localparam logic [BYTE_W-1:0] CODE_DATA    = 8'h00;
    localparam logic [BYTE_W-1:0] CODE_CMD     = 8'h91;
    localparam logic [BYTE_W-1:0] MFR_HI       = 8'h7F;
    localparam logic [BYTE_W-1:0] MFR_LO       = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h01;

    // Addresses.
    localparam logic [ADDR_W-1:0] ADDR_DEFAULT = 10'd1;
    localparam logic [ADDR_W-1:0] ADDR_MAX     = 10'd512;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_LINEAR   = 1'd1;

    // Receive phase.
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_BREAK      = 3'd1,
        PH_START_CODE = 3'd2,
        PH_SKIP       = 3'd3,
        PH_RUN        = 3'd4,
        PH_CMD        = 3'd5,
        PH_SUM_HI     = 3'd6,
        PH_SUM_LO     = 3'd7
    } dmx_phase_t;

    // One result beat.
    typedef struct packed {
        logic              level_valid;
        logic [CH_W-1:0]   channel_index;
        logic [BYTE_W-1:0] level;
        logic              address_write;
        logic [ADDR_W-1:0] active_address;
    } dmx_result_t;

    // Logarithmic dimmer curve.
    localparam logic [BYTE_W-1:0] LOG_CURVE [256] = '{
        8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,
        8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,
        8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd6,
        8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,
        8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd9,8'd9,8'd10,8'd10,8'd10,8'd10,8'd10,8'd11,8'd11,
        8'd11,
        8'd11,8'd12,8'd12,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd14,8'd14,8'd15,
        8'd15,8'd15,8'd16,
        8'd16,8'd17,8'd17,8'd17,8'd18,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,
        8'd21,8'd22,8'd22,
        8'd23,8'd23,8'd24,8'd24,8'd25,8'd26,8'd26,8'd27,8'd27,8'd28,8'd28,8'd29,8'd30,
        8'd30,8'd31,8'd32,
        8'd32,8'd33,8'd34,8'd35,8'd35,8'd36,8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,
        8'd43,8'd44,8'd45,
        8'd46,8'd47,8'd48,8'd49,8'd50,8'd51,8'd52,8'd53,8'd55,8'd56,8'd57,8'd58,8'd60,
        8'd61,8'd62,8'd64,
        8'd65,8'd66,8'd68,8'd69,8'd71,8'd72,8'd74,8'd76,8'd77,8'd79,8'd81,8'd83,8'd84,
        8'd86,8'd88,8'd90,
        8'd92,8'd94,8'd96,8'd98,8'd100,8'd103,8'd105,8'd107,8'd109,8'd112,8'd114,8'd117,
        8'd119,8'd122,8'd125,8'd127,
        8'd130,8'd133,8'd136,8'd139,8'd142,8'd145,8'd148,8'd152,8'd155,8'd158,8'd162,
        8'd165,8'd169,8'd173,8'd177,8'd180,
        8'd184,8'd189,8'd193,8'd197,8'd201,8'd206,8'd210,8'd215,8'd219,8'd224,8'd229,
        8'd234,8'd239,8'd245,8'd250,8'd255
    };

endpackage

/* hw/rtl/dmx512_slot_receiver.sv */
// Top level of the DMX512 slot receiver: decoder plus output buffering.
//
// Input channel: one received serial byte per beat (rx_byte) with break_seen set
// when the byte carried a framing error. A flagged byte restarts the frame.
// Output channel: exactly one result beat per input beat, in order: a channel
// level (level_valid, channel_index, level), an address-command report
// (address_write) and the start address in force (active_address).
// Configuration: cfg_write with cfg_index 0 writes the stored start address,
// index 1 selects linear (1) or logarithmic (0) levels; write only while idle.
// A beat can be taken on every cycle while in_stall is low; the whole
// per-byte decode sits between the input and the result register. A skid
// stage holds one more result, so in_stall rises only when the output has
// been stalled with two results waiting.
// Reset clears the receive phase, counters and checksum, drops any address set
// by command, and sets stored address and linear mode to 1; the block waits
// for a break before decoding.
module dmx512_slot_receiver
    import dmx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 break_seen,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 level_valid,
    output logic [CH_W-1:0]      channel_index,
    output logic [BYTE_W-1:0]    level,
    output logic                 address_write,
    output logic [ADDR_W-1:0]    active_address,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic        accept;
    logic        full;
    dmx_result_t core_result;
    dmx_result_t out_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Per-byte decode.
    dmx_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .break_seen (break_seen),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .result     (core_result)
    );

    // Result register and skid stage.
    dmx_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign level_valid    = out_data.level_valid;
    assign channel_index  = out_data.channel_index;
    assign level          = out_data.level;
    assign address_write  = out_data.address_write;
    assign active_address = out_data.active_address;

    // The skid stage only fills behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid stage holds a beat while the output is empty");

    // After an accepted beat, out_valid is always high in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted beat produced no result");

    // A beat never reports a level and an address command together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(level_valid && address_write))
        else $error("level and address command in one beat");

    // Channel index stays within the channel count and the address in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!level_valid || channel_index < CH_W'(NUM_CHANNELS)) &&
                       active_address >= ADDR_DEFAULT && active_address <= ADDR_MAX))
        else $error("channel index or active address out of range");

endmodule

/* hw/rtl/dmx_core.sv */
// Frame decoder: receive phase, slot and channel counters, command check and level shaping.
module dmx_core
    import dmx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 break_seen,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output dmx_result_t          result
);

    dmx_phase_t          phase_reg, phase_next, phase_in;
    logic [ADDR_W-1:0]   slot_count_reg, slot_count_next, slot_in, slot_inc;
    logic [CH_W-1:0]     channel_count_reg, channel_count_next;
    logic [CH_W:0]       channel_inc;
    logic [SUM_W-1:0]    running_sum_reg, running_sum_next, sum_lo;
    logic                override_valid_reg, override_valid_next;
    logic [ADDR_W-1:0]   override_address_reg, override_address_next;
    logic [BYTE_W-1:0]   command_bytes_reg [CMD_LEN];
    logic                cmd_write;
    logic [CMD_IDX_W-1:0] cmd_idx;
    logic [STORED_W-1:0] stored_address_reg;
    logic                curve_linear_reg;
    logic [ADDR_W-1:0]   cur_address;
    logic [SUM_W-1:0]    cmd_address;
    logic                cmd_ok;
    logic [BYTE_W-1:0]   shaped;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_address_reg <= STORED_W'(ADDR_DEFAULT);
            curve_linear_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STORED_ADDRESS: stored_address_reg <= cfg_data;
                CFG_CURVE_LINEAR:   curve_linear_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Address in force before this byte.
    always_comb
    begin
        if (override_valid_reg)
            cur_address = override_address_reg;
        else if (stored_address_reg >= 16'd1 &&
                 stored_address_reg <= STORED_W'(ADDR_MAX))
            cur_address = stored_address_reg[ADDR_W-1:0];
        else
            cur_address = ADDR_DEFAULT;
    end

    // A break restarts the frame; a slot count past the end stops it.
    always_comb
    begin
        phase_in = break_seen ? PH_BREAK : phase_reg;
        slot_in  = break_seen ? '0 : slot_count_reg;
        if (slot_in > ADDR_W'(MAX_SLOT))
            phase_in = PH_IDLE;
        slot_inc    = slot_in + 1'b1;
        channel_inc = {1'b0, channel_count_reg} + 1'b1;
        sum_lo      = running_sum_reg - {8'd0, rx_byte};
        cmd_address = {command_bytes_reg[3], command_bytes_reg[4]};
        cmd_ok      = (sum_lo == '0) && (command_bytes_reg[0] == MFR_HI) &&
                      (command_bytes_reg[1] == MFR_LO) &&
                      (command_bytes_reg[2] == CMD_SET_ADDR) &&
                      (cmd_address >= 16'd1) && (cmd_address <= SUM_W'(ADDR_MAX));
        shaped      = curve_linear_reg ? rx_byte : LOG_CURVE[rx_byte];
        cmd_idx     = slot_in[CMD_IDX_W-1:0];
    end

    // Next receive phase.
    always_comb
    begin
        phase_next = phase_in;
        case (phase_in)
            PH_BREAK:
                phase_next = PH_START_CODE;
            PH_START_CODE:
            begin
                if (rx_byte == CODE_DATA)
                    phase_next = PH_SKIP;
                else if (rx_byte == CODE_CMD)
                    phase_next = PH_CMD;
                else
                    phase_next = PH_IDLE;
            end
            PH_SKIP:
            begin
                if (slot_inc == cur_address)
                    phase_next = (NUM_CHANNELS <= 1) ? PH_IDLE : PH_RUN;
            end
            PH_RUN:
            begin
                if (channel_inc >= (CH_W+1)'(NUM_CHANNELS))
                    phase_next = PH_IDLE;
            end
            PH_CMD:
            begin
                if (slot_inc >= ADDR_W'(CMD_LEN))
                    phase_next = PH_SUM_HI;
            end
            PH_SUM_HI:
                phase_next = PH_SUM_LO;
            PH_SUM_LO:
                phase_next = PH_IDLE;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // Counters, checksum, address override and the result beat.
    always_comb
    begin
        slot_count_next       = slot_in;
        channel_count_next    = channel_count_reg;
        running_sum_next      = running_sum_reg;
        override_valid_next   = override_valid_reg;
        override_address_next = override_address_reg;
        cmd_write             = 1'b0;
        result                = '0;
        case (phase_in)
            PH_START_CODE:
            begin
                if (rx_byte == CODE_CMD)
                    running_sum_next = '0;
            end
            PH_SKIP:
            begin
                slot_count_next = slot_inc;
                if (slot_inc == cur_address)
                begin
                    result.level_valid = 1'b1;
                    result.level       = shaped;
                    channel_count_next = CH_W'(1);
                end
            end
            PH_RUN:
            begin
                slot_count_next      = slot_inc;
                result.level_valid   = 1'b1;
                result.channel_index = channel_count_reg;
                result.level         = shaped;
                channel_count_next   = channel_inc[CH_W-1:0];
            end
            PH_CMD:
            begin
                cmd_write        = 1'b1;
                slot_count_next  = slot_inc;
                running_sum_next = running_sum_reg + {8'd0, rx_byte};
            end
            PH_SUM_HI:
                running_sum_next = running_sum_reg - {rx_byte, 8'd0};
            PH_SUM_LO:
            begin
                running_sum_next = sum_lo;
                if (cmd_ok)
                begin
                    override_valid_next   = 1'b1;
                    override_address_next = cmd_address[ADDR_W-1:0];
                    result.address_write  = 1'b1;
                end
            end
            default:
                ;
        endcase
        result.active_address = result.address_write ? override_address_next : cur_address;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            slot_count_reg       <= '0;
            channel_count_reg    <= '0;
            running_sum_reg      <= '0;
            override_valid_reg   <= 1'b0;
            override_address_reg <= ADDR_DEFAULT;
        end
        else if (accept)
        begin
            phase_reg            <= phase_next;
            slot_count_reg       <= slot_count_next;
            channel_count_reg    <= channel_count_next;
            running_sum_reg      <= running_sum_next;
            override_valid_reg   <= override_valid_next;
            override_address_reg <= override_address_next;
        end
    end

    // Command byte store; the command phase only sees slot counts below five.
    always_ff @(posedge clk)
    begin
        if (accept && cmd_write && cmd_idx < CMD_IDX_W'(CMD_LEN))
            command_bytes_reg[cmd_idx] <= rx_byte;
    end

endmodule

/* hw/rtl/dmx_obuf.sv */
// Result register with a skid stage between the decoder and the output channel.
module dmx_obuf
    import dmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  dmx_result_t push_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output dmx_result_t out_data
);

    logic        out_valid_reg, skid_valid_reg;
    dmx_result_t out_data_reg, skid_data_reg;
    logic        out_taken;

    assign out_taken = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_taken)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !out_taken)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Beat payloads.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_taken)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !out_taken)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the DMX512 slot receiver: directed frames, commands and random traffic.
module testbench;
    import dmx_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_BYTES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 break_seen = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 level_valid;
    logic [CH_W-1:0]      channel_index;
    logic [BYTE_W-1:0]    level;
    logic                 address_write;
    logic [ADDR_W-1:0]    active_address;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    dmx512_slot_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .break_seen     (break_seen),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .level_valid    (level_valid),
        .channel_index  (channel_index),
        .level          (level),
        .address_write  (address_write),
        .active_address (active_address),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run length guard.
    int unsigned cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Decoder state mirrored by the testbench, plus its copy of the registers.
    dmx_phase_t        rx_state   = PH_IDLE;
    logic [ADDR_W-1:0] slot_num   = '0;
    logic [2:0]        chan_num   = '0;
    logic [7:0]        cmd_buf [CMD_LEN];
    logic [SUM_W-1:0]  cmd_sum    = '0;
    logic              cmd_addr_set = 1'b0;
    logic [ADDR_W-1:0] cmd_addr   = ADDR_DEFAULT;
    logic [CFG_W-1:0]  saved_addr = 16'd1;
    logic              linear_mode = 1'b1;

    dmx_result_t pending_slot_results [$];
    int unsigned bad_beats = 0;
    int unsigned bytes_sent = 0;

    function automatic logic [ADDR_W-1:0] address_in_force();
        if (cmd_addr_set)
            return cmd_addr;
        if (saved_addr >= 1 && saved_addr <= MAX_SLOT)
            return saved_addr[ADDR_W-1:0];
        return ADDR_DEFAULT;
    endfunction

    function automatic logic [BYTE_W-1:0] dim_level(input logic [BYTE_W-1:0] v);
        return linear_mode ? v : LOG_CURVE[v];
    endfunction

    // Advance the mirrored decoder by one received byte and return its result beat.
    function automatic dmx_result_t decode_byte(input logic [BYTE_W-1:0] b, input logic brk);
        dmx_result_t r;
        logic [15:0] new_addr;
        r = '0;
        if (brk)
        begin
            rx_state = PH_BREAK;
            slot_num = '0;
        end
        if (slot_num > MAX_SLOT)
            rx_state = PH_IDLE;
        case (rx_state)
            PH_BREAK:
                rx_state = PH_START_CODE;
            PH_START_CODE:
                if (b == CODE_DATA)
                    rx_state = PH_SKIP;
                else if (b == CODE_CMD)
                begin
                    rx_state = PH_CMD;
                    cmd_sum = '0;
                end
                else
                    rx_state = PH_IDLE;
            PH_SKIP:
            begin
                slot_num = slot_num + 1'b1;
                if (slot_num == address_in_force())
                begin
                    r.level_valid = 1'b1;
                    r.channel_index = '0;
                    r.level = dim_level(b);
                    chan_num = 3'd1;
                    rx_state = (chan_num >= NUM_CHANNELS) ? PH_IDLE : PH_RUN;
                end
            end
            PH_RUN:
            begin
                slot_num = slot_num + 1'b1;
                r.level_valid = 1'b1;
                r.channel_index = chan_num;
                r.level = dim_level(b);
                chan_num = chan_num + 1'b1;
                if (chan_num >= NUM_CHANNELS)
                    rx_state = PH_IDLE;
            end
            PH_CMD:
            begin
                cmd_buf[slot_num % CMD_LEN] = b;
                slot_num = slot_num + 1'b1;
                cmd_sum = cmd_sum + b;
                if (slot_num >= CMD_LEN)
                    rx_state = PH_SUM_HI;
            end
            PH_SUM_HI:
            begin
                cmd_sum = cmd_sum - {b, 8'h00};
                rx_state = PH_SUM_LO;
            end
            PH_SUM_LO:
            begin
                cmd_sum = cmd_sum - b;
                if (cmd_sum == 0 && cmd_buf[0] == MFR_HI && cmd_buf[1] == MFR_LO &&
                    cmd_buf[2] == CMD_SET_ADDR)
                begin
                    new_addr = {cmd_buf[3], cmd_buf[4]};
                    if (new_addr >= 1 && new_addr <= MAX_SLOT)
                    begin
                        cmd_addr_set = 1'b1;
                        cmd_addr = new_addr[ADDR_W-1:0];
                        r.address_write = 1'b1;
                    end
                end
                rx_state = PH_IDLE;
            end
            default:
                rx_state = PH_IDLE;
        endcase
        r.active_address = address_in_force();
        return r;
    endfunction

    // Result beats are compared in order against the mirrored decoder.
    always @(posedge clk)
    begin : check_beat
        dmx_result_t got;
        dmx_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{level_valid, channel_index, level, address_write, active_address};
            if (pending_slot_results.size() == 0)
            begin
                if (bad_beats < 10)
                    $display("unexpected result beat: lv=%0d ch=%0d lev=%0h aw=%0d addr=%0d",
                             got.level_valid, got.channel_index, got.level,
                             got.address_write, got.active_address);
                bad_beats++;
            end
            else
            begin
                want = pending_slot_results.pop_front();
                if (got.level_valid !== want.level_valid ||
                    got.channel_index !== want.channel_index ||
                    got.level !== want.level ||
                    got.address_write !== want.address_write ||
                    got.active_address !== want.active_address)
                begin
                    if (bad_beats < 10)
                    begin
                        $display("mismatch: exp lv=%0d ch=%0d lev=%0h aw=%0d addr=%0d",
                                 want.level_valid, want.channel_index, want.level,
                                 want.address_write, want.active_address);
                        $display("          got lv=%0d ch=%0d lev=%0h aw=%0d addr=%0d",
                                 got.level_valid, got.channel_index, got.level,
                                 got.address_write, got.active_address);
                    end
                    bad_beats++;
                end
            end
        end
    end

    // Output stall: changing patterns, plus a long hold-off on request.
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned seg_left = 0;
    int unsigned stall_mode = 0;
    logic [7:0]  pat_cnt = '0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left <= $urandom_range(20, 200);
                stall_mode <= $urandom_range(0, 3);
            end
            else
                seg_left <= seg_left - 1;
            pat_cnt <= pat_cnt + 1'b1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 2);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (pat_cnt[2:0] < 3);
            endcase
        end
    end

    // Sender side: bursts of beats separated by random gaps when enabled.
    bit          gaps_on = 1'b1;
    int unsigned burst_left = 0;

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic brk);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0)
            burst_left--;
        in_valid <= 1'b1;
        rx_byte <= b;
        break_seen <= brk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_slot_results.push_back(decode_byte(b, brk));
        bytes_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_slot_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_STORED_ADDRESS)
            saved_addr = val;
        else
            linear_mode = val[0];
        @(posedge clk);
    endtask

    task automatic send_break();
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_dimmer_frame(input int n_slots);
        send_break();
        send_byte(CODE_DATA, 1'b0);
        repeat (n_slots) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    // Levels at the ends of the range and around the midpoint.
    task automatic send_edge_levels();
        send_break();
        send_byte(CODE_DATA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hAA, 1'b0);
    endtask

    // Command frame; sum_skew offsets the checksum to corrupt it.
    task automatic send_command(input logic [7:0] id_hi, input logic [7:0] id_lo,
                                input logic [7:0] kind, input logic [15:0] addr,
                                input logic [15:0] sum_skew);
        logic [15:0] csum;
        csum = id_hi + id_lo + kind + addr[15:8] + addr[7:0] + sum_skew;
        send_break();
        send_byte(CODE_CMD, 1'b0);
        send_byte(id_hi, 1'b0);
        send_byte(id_lo, 1'b0);
        send_byte(kind, 1'b0);
        send_byte(addr[15:8], 1'b0);
        send_byte(addr[7:0], 1'b0);
        send_byte(csum[15:8], 1'b0);
        send_byte(csum[7:0], 1'b0);
    endtask

    task automatic test_reset_levels();
        gaps_on = 1'b0;
        send_edge_levels();
        gaps_on = 1'b1;
        send_break();
        send_break();
        send_dimmer_frame(9);
    endtask

    task automatic test_stored_address();
        write_reg(CFG_CURVE_LINEAR, 16'd0);
        write_reg(CFG_STORED_ADDRESS, 16'd0);
        send_edge_levels();
        write_reg(CFG_STORED_ADDRESS, 16'hFFFF);
        send_dimmer_frame(8);
        write_reg(CFG_STORED_ADDRESS, 16'd513);
        send_dimmer_frame(8);
        write_reg(CFG_STORED_ADDRESS, 16'd4);
        send_dimmer_frame(12);
        write_reg(CFG_CURVE_LINEAR, 16'd1);
        send_dimmer_frame(12);
    endtask

    task automatic test_start_codes();
        // Unknown start codes make the block wait for the next break.
        send_break();
        send_byte(8'h01, 1'b0);
        repeat (4) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        send_break();
        send_byte(8'hFF, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0);
        send_break();
        send_byte(8'h90, 1'b0);
        send_byte(8'h91, 1'b0);
        // A break in the middle of a frame restarts it.
        send_dimmer_frame(5);
        send_dimmer_frame(10);
    endtask

    task automatic test_slot_overflow();
        write_reg(CFG_STORED_ADDRESS, 16'd512);
        send_dimmer_frame(520);
        write_reg(CFG_STORED_ADDRESS, 16'd508);
        write_reg(CFG_CURVE_LINEAR, 16'd0);
        send_dimmer_frame(520);
        write_reg(CFG_STORED_ADDRESS, 16'd1);
        write_reg(CFG_CURVE_LINEAR, 16'd1);
    endtask

    task automatic test_address_commands();
        send_command(MFR_HI, MFR_LO, CMD_SET_ADDR, 16'd5, 16'd0);
        send_dimmer_frame(12);
        // Rejected commands leave the address alone.
        send_command(MFR_HI, MFR_LO, CMD_SET_ADDR, 16'd9, 16'd1);
        send_command(8'h7E, MFR_LO, CMD_SET_ADDR, 16'd9, 16'd0);
        send_command(MFR_HI, 8'hFE, CMD_SET_ADDR, 16'd9, 16'd0);
        send_command(MFR_HI, MFR_LO, 8'h02, 16'd9, 16'd0);
        send_command(MFR_HI, MFR_LO, CMD_SET_ADDR, 16'd0, 16'd0);
        send_command(MFR_HI, MFR_LO, CMD_SET_ADDR, 16'd513, 16'd0);
        send_command(MFR_HI, MFR_LO, CMD_SET_ADDR, 16'hFFFF, 16'd0);
        send_command(MFR_HI, MFR_LO, CMD_SET_ADDR, 16'd512, 16'd0);
        send_dimmer_frame(516);
        send_command(MFR_HI, MFR_LO, CMD_SET_ADDR, 16'd2, 16'd0);
        send_dimmer_frame(9);
        // Once a command has set the address, the register no longer matters.
        write_reg(CFG_STORED_ADDRESS, 16'd7);
        send_dimmer_frame(9);
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_req <= ~hold_req;
        send_dimmer_frame(40);
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned start_count;
        int unsigned kind;
        int n;
        logic [7:0] id_hi;
        logic [7:0] id_lo;
        logic [7:0] cmd_kind;
        logic [15:0] addr;
        logic [15:0] skew;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(CFG_CURVE_LINEAR, CFG_W'($urandom_range(0, 1)));
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_STORED_ADDRESS, 16'd0);
                    1: write_reg(CFG_STORED_ADDRESS, 16'd512);
                    2: write_reg(CFG_STORED_ADDRESS, 16'hFFFF);
                    default: write_reg(CFG_STORED_ADDRESS, CFG_W'($urandom_range(0, 65535)));
                endcase
            end
            kind = $urandom_range(0, 9);
            if (kind <= 4)
            begin
                n = int'(address_in_force()) - 1 + $urandom_range(0, 9);
                if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(0, n);
                send_dimmer_frame(n);
            end
            else if (kind <= 7)
            begin
                id_hi = MFR_HI;
                id_lo = MFR_LO;
                cmd_kind = CMD_SET_ADDR;
                skew = '0;
                case ($urandom_range(0, 7))
                    0: addr = 16'd0;
                    1: addr = 16'($urandom_range(513, 65535));
                    default: addr = 16'($urandom_range(1, 20));
                endcase
                if ($urandom_range(0, 7) == 0)
                    id_hi = id_hi ^ (8'd1 << $urandom_range(0, 7));
                if ($urandom_range(0, 7) == 0)
                    id_lo = id_lo ^ (8'd1 << $urandom_range(0, 7));
                if ($urandom_range(0, 7) == 0)
                    cmd_kind = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0)
                    skew = 16'($urandom_range(1, 65535));
                send_command(id_hi, id_lo, cmd_kind, addr, skew);
                repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
            else if (kind == 8)
            begin
                send_break();
                send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
                repeat ($urandom_range(0, 6)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(BYTE_W'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_levels();
        test_stored_address();
        test_start_codes();
        test_slot_overflow();
        test_address_commands();
        test_backpressure();
        test_random_traffic();
        wait_drain();
        repeat (4) @(posedge clk);
        if (bad_beats == 0 && pending_slot_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dmx_pkg.sv
hw/rtl/dmx_core.sv
hw/rtl/dmx_obuf.sv
hw/rtl/dmx512_slot_receiver.sv
tb/testbench.sv
